// ===== src/fata_pkg.sv =====
package fata_pkg;

  // Fixed field widths of the angle path.
  localparam int unsigned BendW  = 7;
  localparam int unsigned TotalW = 24;

  // A full bend is ninety degrees.
  localparam int unsigned FullBend = 90;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMaxReading = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinReading = 1'b1;

  // Defaults for the top level parameters.
  localparam int unsigned WindowLengthDef = 15;
  localparam int unsigned SampleBitsDef   = 10;

endpackage

// ===== src/fata_div.sv =====
// Restoring divider that yields one quotient bit per cycle, most significant first.
// The caller guarantees that the quotient fits in BendW bits.
module fata_div import fata_pkg::*; #(
  parameter int unsigned DividendW = 17,
  parameter int unsigned DivisorW  = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [BendW-1:0]     quotient_o
);

  localparam int unsigned CntW = $clog2(BendW);

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [BendW-1:0]     quo_q, quo_d;
  logic [DividendW-1:0] trial;

  // One compare and subtract against the shifted divisor per cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    trial  = DividendW'(dsr_q) << cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(BendW - 1);
      rem_d  = dividend_i;
      dsr_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d        = rem_q - trial;
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // The last step is flagged in the cycle that resolves the lowest bit.
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

endmodule

// ===== src/flex_angle_travel_accumulator_top.sv =====
// Each accepted word passes through the states Mult, DivB, Upd, Mean and Done; DivB and
// its divide are skipped when the bend is saturated or the calibration span is empty.
// The input stalls until the result word is loaded, so one word is worked on at a time; a
// single bit-serial divider forms the bend scale, and the window mean is a reciprocal multiply.
// Reset clears the calibration to full range, the bend window, its sum, the previous mean
// and the travel total; the block accepts a word in the first cycle after reset.
module flex_angle_travel_accumulator_top import fata_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = WindowLengthDef,
  parameter int unsigned SAMPLE_BITS   = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  input  logic                   restart_total_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BendW-1:0]       bend_degrees_o,
  output logic [BendW-1:0]       average_degrees_o,
  output logic [BendW-1:0]       step_change_o,
  output logic [TotalW-1:0]      total_travel_o
);

  localparam int unsigned SumW      = $clog2(FullBend * WINDOW_LENGTH + 1);
  localparam int unsigned ProdW     = SAMPLE_BITS + BendW;
  localparam int unsigned DividendW = (ProdW > SumW) ? ProdW : SumW;

  // Reciprocal of the window length, exact for every reachable window sum.
  localparam int unsigned     RecipShift = SumW + $clog2(WINDOW_LENGTH);
  localparam int unsigned     RecipW     = SumW + 2;
  localparam int unsigned     MeanProdW  = SumW + RecipW;
  localparam longint unsigned RecipFull  =
    ((64'd1 << RecipShift) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [RecipW-1:0] Recip    = RecipW'(RecipFull);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMult = 3'd1;
  localparam logic [2:0] StDivB = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StMean = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [SAMPLE_BITS-1:0] max_q, min_q;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                   restart_q, restart_d;
  logic [BendW-1:0]       bend_q, bend_d;
  logic [BendW-1:0]       avg_q, avg_d;
  logic [BendW-1:0]       prev_q, prev_d;
  logic [TotalW-1:0]      total_q, total_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [BendW-1:0]       win_q [WINDOW_LENGTH];
  logic                   win_shift;
  logic                   out_valid_q, out_valid_d;
  logic [BendW-1:0]       out_bend_q, out_avg_q, out_step_q;
  logic [TotalW-1:0]      out_total_q;
  logic                   out_load;

  logic [SAMPLE_BITS-1:0] span, offset;
  logic [ProdW-1:0]       prod;
  logic [MeanProdW-1:0]   mean_prod;
  logic [BendW-1:0]       change;
  logic [TotalW-1:0]      total_base;
  logic [TotalW:0]        total_sum;
  logic [TotalW-1:0]      total_next;

  logic                   div_start, div_done;
  logic [DividendW-1:0]   div_dividend;
  logic [SAMPLE_BITS-1:0] div_divisor;
  logic [BendW-1:0]       div_quo;

  // Configuration is always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '1;
      min_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxReading: max_q <= cfg_data_i;
        CfgMinReading: min_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Offset above the calibrated minimum, clamped at zero, times ninety.
  assign span   = max_q - min_q;
  assign offset = (sample_q > min_q) ? (sample_q - min_q) : '0;
  assign prod   = ProdW'(offset) * ProdW'(FullBend);

  // Window mean as a multiply by the scaled reciprocal of the window length.
  assign mean_prod = MeanProdW'(sum_q) * MeanProdW'(Recip);

  // Absolute change of the mean and the saturating travel total.
  assign change     = (avg_q >= prev_q) ? (avg_q - prev_q) : (prev_q - avg_q);
  assign total_base = restart_q ? '0 : total_q;
  assign total_sum  = {1'b0, total_base} + (TotalW + 1)'(change);
  assign total_next = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];

  // The output register frees as soon as its word is taken.
  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // Sequencer around the divider.
  always_comb begin
    state_d      = state_q;
    sample_d     = sample_q;
    restart_d    = restart_q;
    bend_d       = bend_q;
    avg_d        = avg_q;
    prev_d       = prev_q;
    total_d      = total_q;
    sum_d        = sum_q;
    win_shift    = 1'b0;
    div_start    = 1'b0;
    div_dividend = DividendW'(prod);
    div_divisor  = span;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          sample_d  = adc_sample_i;
          restart_d = restart_total_i;
          state_d   = StMult;
        end
      end
      StMult: begin
        if (max_q <= min_q) begin
          bend_d  = '0;
          state_d = StUpd;
        end else if (offset >= span) begin
          bend_d  = BendW'(FullBend);
          state_d = StUpd;
        end else begin
          div_start = 1'b1;
          state_d   = StDivB;
        end
      end
      StDivB: begin
        if (div_done) begin
          bend_d  = div_quo;
          state_d = StUpd;
        end
      end
      StUpd: begin
        sum_d     = sum_q - SumW'(win_q[WINDOW_LENGTH-1]) + SumW'(bend_q);
        win_shift = 1'b1;
        state_d   = StMean;
      end
      StMean: begin
        avg_d   = mean_prod[RecipShift +: BendW];
        state_d = StDone;
      end
      StDone: begin
        if (out_load) begin
          prev_d  = avg_q;
          total_d = total_next;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  // Output valid holds until the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  fata_div #(
    .DividendW(DividendW),
    .DivisorW (SAMPLE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Control state and the running window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      total_q     <= total_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (win_shift) begin
        win_q[0] <= bend_q;
        for (int i = 1; i < WINDOW_LENGTH; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    restart_q <= restart_d;
    bend_q    <= bend_d;
    avg_q     <= avg_d;
    if (out_load) begin
      out_bend_q  <= bend_q;
      out_avg_q   <= avg_q;
      out_step_q  <= change;
      out_total_q <= total_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign bend_degrees_o    = out_bend_q;
  assign average_degrees_o = out_avg_q;
  assign step_change_o     = out_step_q;
  assign total_travel_o    = out_total_q;

endmodule

// ===== src/fata_chk.sv =====
// Port-level checks on the flex angle travel accumulator.
module fata_chk import fata_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BendW-1:0]  bend_degrees_o,
  input logic [BendW-1:0]  average_degrees_o,
  input logic [BendW-1:0]  step_change_o,
  input logic [TotalW-1:0] total_travel_o
);

  // An accepted word keeps the input stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted word");

  // Bend and mean never exceed a full bend.
  a_bend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bend_degrees_o <= BendW'(FullBend)) &&
                    (average_degrees_o <= BendW'(FullBend)))
    else $error("bend or mean above ninety degrees");

  // A mean change can never exceed the mean range.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> step_change_o <= BendW'(FullBend))
    else $error("step change above ninety degrees");

  // A stalled result word stays valid and keeps its travel total and step change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_travel_o) &&
                                   $stable(step_change_o))
    else $error("stalled result word changed");

endmodule

bind flex_angle_travel_accumulator_top fata_chk u_fata_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .bend_degrees_o   (bend_degrees_o),
  .average_degrees_o(average_degrees_o),
  .step_change_o    (step_change_o),
  .total_travel_o   (total_travel_o)
);
